[hdl/imupp_pkg.sv]
// Package for the serial IMU frame parser with yaw unwrapping.
// Holds the frame and result record types and the fixed constants.
// No dependencies.
package imupp_pkg;

	localparam logic [7:0] SYNC_BYTE = 8'h5A;
	localparam logic signed [16:0] CENTIDEG_PER_TURN = 17'sd36000;
	localparam logic [15:0] WRAP_THRESHOLD_RST = 16'd30000;

	// Register byte addresses on the configuration port.
	localparam logic [2:0] ADDR_WRAP_THRESHOLD = 3'd0;

	// Fields of one accepted frame, taken big-endian from the byte window.
	typedef struct packed {
		logic signed [15:0] gyro_x;
		logic signed [15:0] gyro_y;
		logic signed [15:0] gyro_z;
		logic [15:0] yaw_angle;
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic [7:0] device_status;
	} frame_t;

	// One result item. The last member sits in the lowest bits, so the packed
	// value is already the stream data word.
	typedef struct packed {
		logic [31:0] frame_count;
		logic signed [31:0] total_yaw;
		logic signed [15:0] turn_count;
		logic [7:0] device_status;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] roll_angle;
		logic [15:0] yaw_angle;
		logic signed [15:0] gyro_z;
		logic signed [15:0] gyro_y;
		logic signed [15:0] gyro_x;
	} result_t;

endpackage

[hdl/imu_packet_parser_yaw_unwrap_top.sv]
// A matched frame enters stage one with its last byte, then the result register if not stalled.
// Throughput: one byte per cycle unless stalled; window and checksum update per accepted byte.
// A stalled result holds in the output register while one more matched frame waits in stage one.
// Reset (arst_n low) clears the window, checksum, holdoff, turns, previous yaw and frame count,
// and sets wrap_threshold to 30000. Depends on imupp_pkg, imupp_regs, imupp_window, imupp_unwrap.
module imu_packet_parser_yaw_unwrap_top
	import imupp_pkg::*;
#(
	parameter int PACKET_LEN = 18
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] rx_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	// [15:0] gyro_x, [31:16] gyro_y, [47:32] gyro_z, [63:48] yaw_angle,
	// [79:64] roll_angle, [95:80] pitch_angle, [103:96] device_status,
	// [119:104] turn_count, [151:120] total_yaw, [183:152] frame_count
	output logic [183:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [15:0] wrap_threshold;
	logic        advance;
	logic        frame_valid_s1;
	frame_t      frame_s1;
	result_t     result_q;

	imupp_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.wrap_threshold (wrap_threshold)
	);

	imupp_window #(
		.PACKET_LEN (PACKET_LEN)
	) u_window (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.rx_byte        (s_tdata),
		.advance        (advance),
		.frame_valid_s1 (frame_valid_s1),
		.frame_s1       (frame_s1)
	);

	imupp_unwrap u_unwrap (
		.clk            (clk),
		.arst_n         (arst_n),
		.frame_valid_s1 (frame_valid_s1),
		.frame_s1       (frame_s1),
		.wrap_threshold (wrap_threshold),
		.advance        (advance),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.result_q       (result_q)
	);

	assign m_tdata = result_q;

endmodule

[hdl/imupp_regs.sv]
// Configuration register file on an APB-style port.
// Holds the yaw wrap threshold; depends on imupp_pkg.
module imupp_regs
	import imupp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [15:0] wrap_threshold
);

	logic [15:0] thr_q;
	logic        hit;

	assign pready = 1'b1;
	assign hit = (paddr[2] == ADDR_WRAP_THRESHOLD[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= WRAP_THRESHOLD_RST;
		end else if (psel && penable && pwrite && hit) begin
			thr_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (hit) begin
			prdata = {16'd0, thr_q};
		end
	end

	assign wrap_threshold = thr_q;

endmodule

[hdl/imupp_window.sv]
// Byte window, running checksum, holdoff and frame match, with the first
// pipeline register holding the fields of a matched frame. Uses imupp_pkg.
module imupp_window
	import imupp_pkg::*;
#(
	parameter int PACKET_LEN = 18
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       advance,
	output logic       frame_valid_s1,
	output frame_t     frame_s1
);

	localparam int HW = $clog2(PACKET_LEN);
	localparam logic [HW-1:0] HOLDOFF_LEN = HW'(PACKET_LEN - 1);

	logic [7:0]    win_q [PACKET_LEN];
	logic [7:0]    win_d [PACKET_LEN];
	logic [7:0]    sum_q;
	logic [7:0]    sum_d;
	logic [HW-1:0] holdoff_q;
	logic          accept;
	logic          match;
	frame_t        frame_d;

	assign in_ready = !frame_valid_s1 || advance;
	assign accept = in_valid && in_ready;

	always_comb begin
		for (int i = 0; i < PACKET_LEN - 1; i++) begin
			win_d[i] = win_q[i + 1];
		end
		win_d[PACKET_LEN - 1] = rx_byte;
		// The sum covers every window byte but the newest one.
		sum_d = sum_q - win_q[0] + win_q[PACKET_LEN - 1];
		match = (holdoff_q == '0) && (win_d[0] == SYNC_BYTE) && (win_d[1] == SYNC_BYTE)
			&& (sum_d == win_d[PACKET_LEN - 1]);
		frame_d.gyro_x        = {win_d[4], win_d[5]};
		frame_d.gyro_y        = {win_d[6], win_d[7]};
		frame_d.gyro_z        = {win_d[8], win_d[9]};
		frame_d.yaw_angle     = {win_d[10], win_d[11]};
		frame_d.roll_angle    = {win_d[12], win_d[13]};
		frame_d.pitch_angle   = {win_d[14], win_d[15]};
		frame_d.device_status = win_d[16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PACKET_LEN; i++) begin
				win_q[i] <= 8'd0;
			end
			sum_q <= 8'd0;
			holdoff_q <= '0;
		end else if (accept) begin
			win_q <= win_d;
			sum_q <= sum_d;
			if (holdoff_q != '0) begin
				holdoff_q <= holdoff_q - HW'(1);
			end else if (match) begin
				holdoff_q <= HOLDOFF_LEN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			frame_valid_s1 <= in_valid && match;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && match) begin
			frame_s1 <= frame_d;
		end
	end

	a_holdoff_load: assert property (@(posedge clk) disable iff (!arst_n)
		accept && match |=> holdoff_q == HOLDOFF_LEN)
		else $error("holdoff not loaded after a matched frame");

	a_no_match_in_holdoff: assert property (@(posedge clk) disable iff (!arst_n)
		accept && holdoff_q != '0 |=> !frame_valid_s1)
		else $error("frame taken during holdoff");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid_s1 && !advance |=> frame_valid_s1 && $stable(frame_s1))
		else $error("stalled frame lost from first stage");

endmodule

[hdl/imupp_unwrap.sv]
// Yaw unwrapping, total yaw, frame counter and the result register.
// Uses imupp_pkg.
module imupp_unwrap
	import imupp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        frame_valid_s1,
	input  frame_t      frame_s1,
	input  logic [15:0] wrap_threshold,
	output logic        advance,
	output logic        out_valid,
	input  logic        out_ready,
	output result_t     result_q
);

	logic [15:0]        prev_yaw_q;
	logic signed [15:0] turns_q;
	logic [31:0]        frame_q;
	logic signed [16:0] diff;
	logic signed [16:0] thr;
	logic signed [15:0] turns_d;
	logic signed [33:0] total;
	logic               take;

	assign advance = !out_valid || out_ready;
	assign take = advance && frame_valid_s1;

	always_comb begin
		diff = $signed({1'b0, frame_s1.yaw_angle}) - $signed({1'b0, prev_yaw_q});
		thr = $signed({1'b0, wrap_threshold});
		turns_d = turns_q;
		// A large drop means yaw crossed the wrap edge upwards, a large rise downwards.
		if (diff < -thr) begin
			if (turns_q != 16'sh7FFF) begin
				turns_d = turns_q + 16'sd1;
			end
		end else if (diff > thr) begin
			if (turns_q != -16'sh8000) begin
				turns_d = turns_q - 16'sd1;
			end
		end
		total = 34'($signed({1'b0, frame_s1.yaw_angle}))
			+ 34'(CENTIDEG_PER_TURN) * 34'(turns_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			prev_yaw_q <= 16'd0;
			turns_q <= 16'sd0;
			frame_q <= 32'd0;
		end else if (advance) begin
			out_valid <= frame_valid_s1;
			if (frame_valid_s1) begin
				prev_yaw_q <= frame_s1.yaw_angle;
				turns_q <= turns_d;
				frame_q <= frame_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q.frame_count   <= frame_q + 32'd1;
			result_q.total_yaw     <= total[31:0];
			result_q.turn_count    <= turns_d;
			result_q.device_status <= frame_s1.device_status;
			result_q.pitch_angle   <= frame_s1.pitch_angle;
			result_q.roll_angle    <= frame_s1.roll_angle;
			result_q.yaw_angle     <= frame_s1.yaw_angle;
			result_q.gyro_z        <= frame_s1.gyro_z;
			result_q.gyro_y        <= frame_s1.gyro_y;
			result_q.gyro_x        <= frame_s1.gyro_x;
		end
	end

	a_turn_step: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> turns_q == $past(turns_q) || turns_q == $past(turns_q) + 16'sd1
			|| turns_q == $past(turns_q) - 16'sd1)
		else $error("turn count moved by more than one turn");

	a_frame_count: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> frame_q == $past(frame_q) + 32'd1 && result_q.frame_count == frame_q)
		else $error("frame counter out of step with results");

	a_state_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(turns_q) && $stable(prev_yaw_q))
		else $error("unwrap state changed without a frame");

endmodule

[dv/imu_packet_parser_yaw_unwrap_top_tb.sv]
// Self-checking testbench for the IMU frame parser with yaw unwrapping: byte streams are
// fed in, decoded frames are predicted and compared field by field with the result stream.
// Depends on imupp_pkg and imu_packet_parser_yaw_unwrap_top.
class yaw_frame_scoreboard;
	logic [7:0] window[];
	logic [7:0] window_sum;
	logic [4:0] holdoff;
	logic [15:0] last_yaw;
	logic signed [15:0] turns;
	logic [31:0] frames_seen;
	logic [15:0] wrap_threshold;
	imupp_pkg::result_t due_frames[$];
	int decoded;
	int errors;
	int peak_turns;
	int lowest_turns;

	function new(int frame_len);
		window = new[frame_len];
		foreach (window[i])
			window[i] = 8'h00;
		window_sum = 8'h00;
		holdoff = 5'd0;
		last_yaw = 16'h0000;
		turns = 16'sd0;
		frames_seen = 32'd0;
		wrap_threshold = imupp_pkg::WRAP_THRESHOLD_RST;
		decoded = 0;
		errors = 0;
		peak_turns = 0;
		lowest_turns = 0;
	endfunction

	// Slides one accepted byte into the window and queues the frame it completes, if any.
	function void take_byte(logic [7:0] rx);
		int n;
		int diff;
		int thr;
		int t;
		logic [15:0] yaw;
		imupp_pkg::result_t r;
		n = window.size();
		window_sum = window_sum - window[0] + window[n-1];
		for (int i = 0; i < n - 1; i++)
			window[i] = window[i+1];
		window[n-1] = rx;
		if (holdoff != 5'd0) begin
			holdoff = holdoff - 5'd1;
			return;
		end
		if (window[0] != imupp_pkg::SYNC_BYTE || window[1] != imupp_pkg::SYNC_BYTE)
			return;
		if (window_sum != window[n-1])
			return;
		holdoff = 5'(n - 1);
		yaw = {window[10], window[11]};
		diff = int'(yaw) - int'(last_yaw);
		thr = int'(wrap_threshold);
		t = turns;
		// A large drop means the yaw went past the top of its range, so one turn up.
		if (diff < -thr) begin
			if (t < 32767)
				t++;
		end else if (-diff < -thr) begin
			if (t > -32768)
				t--;
		end
		turns = 16'(t);
		last_yaw = yaw;
		frames_seen = frames_seen + 32'd1;
		decoded++;
		if (t > peak_turns)
			peak_turns = t;
		if (t < lowest_turns)
			lowest_turns = t;
		r.gyro_x = {window[4], window[5]};
		r.gyro_y = {window[6], window[7]};
		r.gyro_z = {window[8], window[9]};
		r.yaw_angle = yaw;
		r.roll_angle = {window[12], window[13]};
		r.pitch_angle = {window[14], window[15]};
		r.device_status = window[16];
		r.turn_count = turns;
		r.total_yaw = int'(yaw) + 36000 * t;
		r.frame_count = frames_seen;
		due_frames.push_back(r);
	endfunction

	function void cmp(string name, longint want, longint seen);
		if (want != seen) begin
			$error("%s: expected %0d, got %0d", name, want, seen);
			errors++;
		end
	endfunction

	function void check_frame(imupp_pkg::result_t got);
		imupp_pkg::result_t want;
		if (due_frames.size() == 0) begin
			$error("frame result arrived with none outstanding (frame_count %0d)",
				got.frame_count);
			errors++;
			return;
		end
		want = due_frames.pop_front();
		cmp("gyro_x", want.gyro_x, got.gyro_x);
		cmp("gyro_y", want.gyro_y, got.gyro_y);
		cmp("gyro_z", want.gyro_z, got.gyro_z);
		cmp("yaw_angle", want.yaw_angle, got.yaw_angle);
		cmp("roll_angle", want.roll_angle, got.roll_angle);
		cmp("pitch_angle", want.pitch_angle, got.pitch_angle);
		cmp("device_status", want.device_status, got.device_status);
		cmp("turn_count", want.turn_count, got.turn_count);
		cmp("total_yaw", want.total_yaw, got.total_yaw);
		cmp("frame_count", want.frame_count, got.frame_count);
	endfunction
endclass

module imu_packet_parser_yaw_unwrap_top_tb;
	import imupp_pkg::*;

	localparam int FRAME_LEN = 18;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 6;

	typedef enum {FR_GOOD, FR_TAIL_SYNC, FR_HEADLESS, FR_BAD_SUM, FR_BAD_SYNC} frame_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00;      // [7:0] rx_byte
	logic m_tvalid;
	logic m_tready = 1'b0;
	// [15:0] gyro_x, [31:16] gyro_y, [47:32] gyro_z, [63:48] yaw_angle,
	// [79:64] roll_angle, [95:80] pitch_angle, [103:96] device_status,
	// [119:104] turn_count, [151:120] total_yaw, [183:152] frame_count
	logic [183:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = 3'd0;
	logic [31:0] pwdata = 32'h0;
	logic [31:0] prdata;
	logic pready;

	yaw_frame_scoreboard sb;
	logic [7:0] burst[$];
	int send_idle_pct = 0;
	int stall_pct = 0;
	int bytes_sent = 0;
	int quiet_cycles = 0;

	imu_packet_parser_yaw_unwrap_top #(.PACKET_LEN(FRAME_LEN)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_frame(result_t'(m_tdata));
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("stalled for %0d cycles with %0d frames outstanding",
				quiet_cycles, sb.due_frames.size());
			$display("imu_packet_parser_yaw_unwrap_top_tb: done, errors");
			$finish;
		end
	end

	function automatic logic [15:0] rand_word();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_yaw();
		case ($urandom_range(4))
			0: return 16'($urandom_range(35999));
			1: return 16'($urandom);
			2: return 16'($urandom_range(99));
			3: return 16'(35900 + $urandom_range(99));
			default: return 16'(65535 - $urandom_range(99));
		endcase
	endfunction

	// Builds one frame into the burst. A tail-sync frame ends in two sync bytes, so that a
	// headless frame after it would complete a match inside the holdoff.
	function automatic void push_frame(input logic [15:0] gx, gy, gz, yaw, roll, pitch,
			input logic [7:0] status, input frame_kind_t kind);
		logic [7:0] f [FRAME_LEN-1];
		logic [7:0] s;
		int i;
		f[0] = SYNC_BYTE;
		f[1] = (kind == FR_BAD_SYNC) ? SYNC_BYTE ^ 8'($urandom_range(1, 255)) : SYNC_BYTE;
		f[2] = 8'($urandom);
		f[3] = 8'($urandom);
		{f[4], f[5]} = gx;
		{f[6], f[7]} = gy;
		{f[8], f[9]} = gz;
		{f[10], f[11]} = yaw;
		{f[12], f[13]} = roll;
		{f[14], f[15]} = pitch;
		f[16] = (kind == FR_TAIL_SYNC) ? SYNC_BYTE : status;
		s = 8'h00;
		for (i = 0; i < FRAME_LEN - 1; i++)
			s += f[i];
		if (kind == FR_TAIL_SYNC) begin
			f[2] = f[2] + SYNC_BYTE - s;
			s = SYNC_BYTE;
		end else if (kind == FR_BAD_SUM) begin
			s = s ^ 8'($urandom_range(1, 255));
		end
		for (i = (kind == FR_HEADLESS) ? 2 : 0; i < FRAME_LEN - 1; i++)
			burst.push_back(f[i]);
		burst.push_back(s);
	endfunction

	function automatic void push_random_frame(input frame_kind_t kind);
		push_frame(rand_word(), rand_word(), rand_word(), rand_yaw(), rand_word(), rand_word(),
			8'($urandom), kind);
	endfunction

	task automatic send_byte(input logic [7:0] rx);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= rx;
		do
			@(posedge clk);
		while (!s_tready);
		sb.take_byte(rx);
		bytes_sent++;
	endtask

	task automatic send_burst();
		while (burst.size() != 0)
			send_byte(burst.pop_front());
	endtask

	task automatic apb_access(input bit wr, input logic [31:0] data, output logic [31:0] rd);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_WRAP_THRESHOLD;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// The threshold only changes once the block has drained every frame in flight.
	task automatic set_threshold(input logic [15:0] thr);
		logic [31:0] rd;
		s_tvalid <= 1'b0;
		while (sb.due_frames.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		apb_access(1'b1, {16'h0000, thr}, rd);
		sb.wrap_threshold = thr;
		apb_access(1'b0, 32'h0, rd);
		sb.cmp("wrap_threshold", thr, rd[15:0]);
	endtask

	task automatic run_random_phase(input int idle_pct, input int stall_in, input logic [15:0] thr);
		int first_byte;
		int pick;
		int n;
		set_threshold(thr);
		send_idle_pct = idle_pct;
		stall_pct = stall_in;
		first_byte = bytes_sent;
		while (bytes_sent - first_byte < 60) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				push_random_frame(FR_GOOD);
			end else if (pick < 70) begin
				push_random_frame(FR_TAIL_SYNC);
				push_random_frame(FR_HEADLESS);
			end else if (pick < 82) begin
				n = $urandom_range(1, 12);
				repeat (n) burst.push_back(($urandom_range(3) == 0) ? SYNC_BYTE : 8'($urandom));
			end else if (pick < 91) begin
				push_random_frame(FR_BAD_SUM);
			end else if (pick < 96) begin
				push_random_frame(FR_BAD_SYNC);
			end else begin
				// A frame cut short, keeping anywhere from its first byte to all but its checksum.
				push_random_frame(FR_GOOD);
				n = $urandom_range(1, FRAME_LEN - 1);
				repeat (n) void'(burst.pop_back());
			end
			send_burst();
		end
	endtask

	initial begin
		logic [31:0] rd;
		sb = new(FRAME_LEN);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_access(1'b0, 32'h0, rd);
		sb.cmp("wrap_threshold", WRAP_THRESHOLD_RST, rd[15:0]);

		// Directed part at the reset threshold: the first frame lands straight on the zeroed
		// window, then field extremes, wraps both ways, the threshold boundary and the holdoff.
		push_frame(16'h8000, 16'h7FFF, 16'h0000, 16'd0, 16'h8000, 16'h7FFF, 8'h00, FR_GOOD);
		push_frame(16'hFFFF, 16'h0001, 16'h8000, 16'd35000, 16'h7FFF, 16'h8000, 8'h00,
			FR_TAIL_SYNC);
		push_frame(16'h1234, 16'h5678, 16'h9ABC, 16'd35500, 16'h0001, 16'hFFFF, 8'h11,
			FR_HEADLESS);
		push_frame(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd100, 16'h0000, 16'h0000, 8'hFF, FR_GOOD);
		push_frame(16'h8000, 16'h8000, 16'h8000, 16'd65535, 16'h8000, 16'h8000, 8'h80, FR_GOOD);
		push_frame(16'h0000, 16'hFFFF, 16'h0000, 16'd0, 16'hFFFF, 16'h0000, 8'h01, FR_GOOD);
		push_frame(16'h0102, 16'h0304, 16'h0506, 16'd30000, 16'h0708, 16'h090A, 8'h5A, FR_GOOD);
		push_frame(16'h0102, 16'h0304, 16'h0506, 16'd0, 16'h0708, 16'h090A, 8'h5A, FR_GOOD);
		push_frame(16'hAAAA, 16'h5555, 16'hAAAA, 16'd1234, 16'h5555, 16'hAAAA, 8'h33, FR_BAD_SUM);
		push_frame(16'hAAAA, 16'h5555, 16'hAAAA, 16'd1234, 16'h5555, 16'hAAAA, 8'h33, FR_BAD_SYNC);
		repeat (5) burst.push_back(8'h00);
		send_burst();

		run_random_phase(0, 0, 16'd0);
		run_random_phase(78, 0, 16'd65535);
		run_random_phase(0, 78, 16'($urandom));
		run_random_phase(19, 19, 16'd18000);

		// At zero threshold any fall in yaw counts one turn up: a full-scale drop follows,
		// then a repeated value that leaves the count alone.
		set_threshold(16'd0);
		send_idle_pct = 0;
		stall_pct = 0;
		push_random_frame(FR_GOOD);
		push_frame(rand_word(), rand_word(), rand_word(), 16'd65535, rand_word(), rand_word(),
			8'($urandom), FR_GOOD);
		push_frame(rand_word(), rand_word(), rand_word(), 16'd0, rand_word(), rand_word(),
			8'($urandom), FR_GOOD);
		push_frame(rand_word(), rand_word(), rand_word(), 16'd0, rand_word(), rand_word(),
			8'($urandom), FR_GOOD);
		send_burst();

		s_tvalid <= 1'b0;
		while (sb.due_frames.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Fed %0d bytes under five threshold and idling mixes; %0d frames decoded.",
			bytes_sent, sb.decoded);
		$display("Turn count ranged from %0d to %0d; %0d mismatches.",
			sb.lowest_turns, sb.peak_turns, sb.errors);
		if (sb.errors == 0)
			$display("imu_packet_parser_yaw_unwrap_top_tb: done, clean");
		else
			$display("imu_packet_parser_yaw_unwrap_top_tb: done, errors");
		$finish;
	end

endmodule
